/* sv/wildcard_glob_matcher_assert.svh */
// Assertion macros for the glob matcher: implication checks on the block's clock and reset.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WGM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WGM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wgm_pkg.sv */
// Shared types and constants for the glob matcher.
package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 32;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	// One command as it leaves the input stage.
	typedef struct packed {
		logic       fire;
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

endpackage

/* sv/wgm_store.sv */
// Pattern store with length, overflow flag and per-position match vectors.
module wgm_store #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wgm_pkg::cmd_t          cmd,
	output logic [MAX_PATTERN-1:0] star_vec,
	output logic [MAX_PATTERN-1:0] step_vec,
	output logic [LEN_W-1:0]       len,
	output logic                   ovf
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]       store_q [MAX_PATTERN];
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             full;
	logic             do_append;

	assign full      = (len_q == LEN_W'(MAX_PATTERN));
	assign do_append = cmd.fire && (cmd.op == wgm_pkg::OP_APPEND);

	always_ff @(posedge clk) begin
		if (do_append && !full) begin
			store_q[len_q[IDX_W-1:0]] <= cmd.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.fire) begin
			unique case (cmd.op)
				wgm_pkg::OP_CLEAR: begin
					len_q <= '0;
					ovf_q <= 1'b0;
				end
				wgm_pkg::OP_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + LEN_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Only filled positions take part; a star never also steps.
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			star_vec[i] = (LEN_W'(i) < len_q) && (store_q[i] == wgm_pkg::STAR_BYTE);
			step_vec[i] = (LEN_W'(i) < len_q) && (store_q[i] != wgm_pkg::STAR_BYTE)
				&& ((store_q[i] == wgm_pkg::ANY_BYTE) || (store_q[i] == cmd.ch));
		end
	end

	assign len = len_q;
	assign ovf = ovf_q;

endmodule

/* sv/wgm_nfa.sv */
// Active position set with star closure and one-byte advance.
module wgm_nfa #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wgm_pkg::cmd_t          cmd,
	input  logic [MAX_PATTERN-1:0] star_vec,
	input  logic [MAX_PATTERN-1:0] step_vec,
	input  logic [LEN_W-1:0]       len,
	output logic                   match
);

	localparam int LEVELS = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN:0] act_q;
	logic [MAX_PATTERN:0] closed;
	logic [MAX_PATTERN:0] nxt;
	logic [MAX_PATTERN:0] g_lv [LEVELS+1];
	logic [MAX_PATTERN:0] p_lv [LEVELS+1];

	// Parallel prefix: a live star at i makes i+1 live, through runs of stars.
	always_comb begin
		g_lv[0] = act_q;
		p_lv[0] = {star_vec, 1'b0};
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j <= MAX_PATTERN; j++) begin
				if (j >= (1 << l)) begin
					g_lv[l+1][j] = g_lv[l][j] | (p_lv[l][j] & g_lv[l][j - (1 << l)]);
					p_lv[l+1][j] = p_lv[l][j] & p_lv[l][j - (1 << l)];
				end else begin
					g_lv[l+1][j] = g_lv[l][j];
					p_lv[l+1][j] = p_lv[l][j];
				end
			end
		end
		closed = g_lv[LEVELS];
	end

	always_comb begin
		nxt = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			nxt[i]   = nxt[i] | (closed[i] & star_vec[i]);
			nxt[i+1] = nxt[i+1] | (closed[i] & step_vec[i]);
		end
	end

	assign match = closed[len];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= (MAX_PATTERN+1)'(1);
		end else if (cmd.fire) begin
			unique case (cmd.op)
				wgm_pkg::OP_TEXT:   act_q <= nxt;
				wgm_pkg::OP_APPEND: act_q <= act_q;
				default:            act_q <= (MAX_PATTERN+1)'(1);
			endcase
		end
	end

endmodule

/* sv/wildcard_glob_matcher.sv */
// Top level of the glob matcher: input stage, pattern store, position set, result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------
//  input    | in_valid / in_stall | opcode, ch
//  output   | out_valid/out_stall | match, overflow
//
// Every item passes through the registered input stage; a new item may enter each cycle unless in_stall holds it.
// An end-of-text item loads its result into the result register as it is processed.
// The longest combinational path is the star-closure prefix plus the byte compares over the store.
// Reset empties the pattern, clears overflow and restarts the position set.
// in_stall rises only when an end-of-text item waits behind an unread, stalled result.
module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       match,
	output logic       overflow
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// Input stage registers.
	logic            valid_s1;
	wgm_pkg::op_t    op_s1;
	logic [7:0]      ch_s1;

	// Result registers.
	logic            out_valid_q;
	logic            match_q;
	logic            overflow_q;

	logic            advance_s1;
	logic            fire;
	wgm_pkg::cmd_t   cmd;

	logic [MAX_PATTERN-1:0] star_vec;
	logic [MAX_PATTERN-1:0] step_vec;
	logic [LEN_W-1:0]       len;
	logic                   ovf;
	logic                   match_now;

	// Only an end-of-text item needs room in the result register.
	assign advance_s1 = (op_s1 != wgm_pkg::OP_END) || !out_valid_q || !out_stall;
	assign fire       = valid_s1 && advance_s1;
	assign in_stall   = valid_s1 && !advance_s1;

	assign cmd.fire = fire;
	assign cmd.op   = op_s1;
	assign cmd.ch   = ch_s1;

	// Take a new item whenever the stage is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload while the item waits.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= wgm_pkg::op_t'(opcode);
			ch_s1 <= ch;
		end
	end

	wgm_store #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.star_vec (star_vec),
		.step_vec (step_vec),
		.len      (len),
		.ovf      (ovf)
	);

	wgm_nfa #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_nfa (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.star_vec (star_vec),
		.step_vec (step_vec),
		.len      (len),
		.match    (match_now)
	);

	// Load a result on end of text; drop it once the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && (op_s1 == wgm_pkg::OP_END)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (op_s1 == wgm_pkg::OP_END)) begin
			match_q    <= match_now;
			overflow_q <= ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign match     = match_q;
	assign overflow  = overflow_q;

`include "wildcard_glob_matcher_assert.svh"

	`WGM_ASSERT_NOW(a_end_has_room, fire && (op_s1 == wgm_pkg::OP_END), !(out_valid_q && out_stall), "end-of-text item overwrote a stalled result")
	`WGM_ASSERT_NEXT(a_no_spurious_result, fire && (op_s1 != wgm_pkg::OP_END) && !out_valid_q, !out_valid_q, "result appeared without end of text")
	`WGM_ASSERT_NEXT(a_clear_empties, fire && (op_s1 == wgm_pkg::OP_CLEAR), (len == '0) && !ovf, "clear left pattern length or overflow set")

endmodule

/* dv/wildcard_glob_matcher_test.sv */
// Self-checking testbench for the glob matcher: directed and random pattern/text streams.
module wildcard_glob_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAT_DEPTH = wgm_pkg::MAX_PATTERN_DEF;
	localparam int ITEM_GOAL = 900;
	localparam int HOLD_CYCLES = 300;

	// One end-of-text verdict as the block reports it.
	typedef struct packed {
		logic match;
		logic overflow;
	} verdict_t;

	// Tracks the pattern and the live position set, and queues the verdict each
	// end-of-text item must produce. Live bits are kept without the star closure;
	// the closure is applied against the current pattern whenever the set is used.
	class glob_verdicts;
		logic [7:0] pat_bytes [PAT_DEPTH];
		int unsigned pat_len;
		logic [PAT_DEPTH:0] live;
		bit spilled;
		verdict_t awaited [$];
		int unsigned failures;

		function new();
			pat_len = 0;
			spilled = 1'b0;
			live = (PAT_DEPTH + 1)'(1);
			failures = 0;
		endfunction

		// Let every live star also open the position after it; ascending order
		// carries runs of stars through in one pass.
		function logic [PAT_DEPTH:0] star_closure(logic [PAT_DEPTH:0] s);
			for (int i = 0; i < pat_len; i++)
				if (s[i] && pat_bytes[i] == wgm_pkg::STAR_BYTE)
					s[i + 1] = 1'b1;
			return s;
		endfunction

		function void note_item(wgm_pkg::op_t op, logic [7:0] c);
			logic [PAT_DEPTH:0] s;
			logic [PAT_DEPTH:0] nxt;
			verdict_t v;
			case (op)
				wgm_pkg::OP_CLEAR: begin
					pat_len = 0;
					spilled = 1'b0;
					live = (PAT_DEPTH + 1)'(1);
				end
				wgm_pkg::OP_APPEND: begin
					// drop the byte once the store is full and remember it
					if (pat_len < PAT_DEPTH) begin
						pat_bytes[pat_len] = c;
						pat_len++;
					end else begin
						spilled = 1'b1;
					end
				end
				wgm_pkg::OP_TEXT: begin
					s = star_closure(live);
					nxt = '0;
					for (int i = 0; i < pat_len; i++) begin
						if (s[i]) begin
							if (pat_bytes[i] == wgm_pkg::STAR_BYTE)
								nxt[i] = 1'b1;
							else if (pat_bytes[i] == wgm_pkg::ANY_BYTE || pat_bytes[i] == c)
								nxt[i + 1] = 1'b1;
						end
					end
					live = nxt;
				end
				default: begin
					s = star_closure(live);
					v.match = s[pat_len];
					v.overflow = spilled;
					awaited.insert(awaited.size(), v);
					live = (PAT_DEPTH + 1)'(1);
				end
			endcase
		endfunction

		function void check_verdict(logic m, logic ov);
			verdict_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: match %0b overflow %0b", m, ov);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (m !== want.match) begin
				$error("match: expected %0b, got %0b", want.match, m);
				failures++;
			end
			if (ov !== want.overflow) begin
				$error("overflow: expected %0b, got %0b", want.overflow, ov);
				failures++;
			end
		endfunction

		function bit drained();
			return awaited.size() == 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] opcode;
	logic [7:0] ch;
	logic out_valid;
	logic out_stall;
	logic match;
	logic overflow;

	glob_verdicts verdicts;
	int unsigned items_sent;
	bit calm;          // sender runs back to back while set
	bit hold_results;  // asks the receiver for one long hold-off
	logic [7:0] glob_pat [$];  // stimulus-side copy of the pattern, used to aim texts

	wildcard_glob_matcher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.ch(ch),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match(match),
		.overflow(overflow)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sample both handshakes at the edge; check the result before noting the
	// input so that an empty queue is never masked by a same-edge end item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				verdicts.check_verdict(match, overflow);
			if (in_valid && !in_stall)
				verdicts.note_item(wgm_pkg::op_t'(opcode), ch);
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Favor a few letters so that literal compares hit, but keep the full byte range.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 2));
			4: return wgm_pkg::STAR_BYTE;
			5: return wgm_pkg::ANY_BYTE;
			6: return 8'h00;
			7: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_pattern_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return wgm_pkg::STAR_BYTE;
			3, 4: return wgm_pkg::ANY_BYTE;
			default: return pick_byte();
		endcase
	endfunction

	// Offer one item, hold it until accepted, then maybe drop valid for a gap.
	task automatic send_item(input wgm_pkg::op_t op, input logic [7:0] c);
		int unsigned gap;
		in_valid <= 1'b1;
		opcode <= op;
		ch <= c;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		items_sent++;
		gap = calm ? 0 : idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_append(input logic [7:0] c);
		if (glob_pat.size() < PAT_DEPTH)
			glob_pat.insert(glob_pat.size(), c);
		send_item(wgm_pkg::OP_APPEND, c);
	endtask

	task automatic send_clear();
		glob_pat.delete();
		send_item(wgm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_end();
		send_item(wgm_pkg::OP_END, 8'($urandom_range(0, 255)));
	endtask

	// Load a fresh pattern; a few are long enough to spill past the store.
	task automatic load_pattern();
		int unsigned len;
		send_clear();
		if ($urandom_range(0, 99) < 8)
			len = $urandom_range(PAT_DEPTH - 4, PAT_DEPTH + 4);
		else
			len = $urandom_range(0, 8);
		repeat (len) send_append(pick_pattern_byte());
	endtask

	// Stream one text and its end item. An aimed text expands the pattern so it
	// should match, unless a stray byte or a late append breaks it.
	task automatic send_text(input bit aimed, input bit late_append);
		logic [7:0] pat [$];
		pat = glob_pat;
		if (aimed) begin
			foreach (pat[i]) begin
				if (pat[i] == wgm_pkg::STAR_BYTE)
					repeat ($urandom_range(0, 3)) send_item(wgm_pkg::OP_TEXT, pick_byte());
				else if (pat[i] == wgm_pkg::ANY_BYTE)
					send_item(wgm_pkg::OP_TEXT, pick_byte());
				else
					send_item(wgm_pkg::OP_TEXT, pat[i]);
			end
			if ($urandom_range(0, 4) == 0)
				send_item(wgm_pkg::OP_TEXT, pick_byte());
		end else begin
			repeat ($urandom_range(0, 6)) send_item(wgm_pkg::OP_TEXT, pick_byte());
		end
		if (late_append)
			send_append(pick_pattern_byte());
		send_end();
	endtask

	task automatic wait_drained();
		while (!verdicts.drained())
			@(posedge clk);
	endtask

	// Receiver: alternate between quiet stretches and stall-heavy ones, and grant
	// one long hold-off on request so that results back up into the input.
	initial begin
		int unsigned stall_left;
		int unsigned mode_left;
		int unsigned busy_pct;
		stall_left = 0;
		mode_left = 0;
		busy_pct = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
					0: busy_pct = 0;
					1: busy_pct = 20;
					default: busy_pct = 60;
				endcase
			end
			mode_left--;
			if (hold_results) begin
				hold_results = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && busy_pct != 0 &&
					$urandom_range(1, 100) <= busy_pct) begin
				stall_left = 1 + idle_gap();
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("FAIL wildcard_glob_matcher");
		$finish;
	end

	initial begin
		bit pressed;
		bit paused;
		int unsigned r;
		verdicts = new();
		items_sent = 0;
		calm = 1'b0;
		hold_results = 1'b0;
		pressed = 1'b0;
		paused = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= wgm_pkg::OP_CLEAR;
		ch <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pattern against empty and non-empty text.
		send_end();
		send_item(wgm_pkg::OP_TEXT, 8'h00);
		send_end();
		// A lone star takes anything, including nothing.
		send_append(wgm_pkg::STAR_BYTE);
		send_end();
		send_item(wgm_pkg::OP_TEXT, 8'hFF);
		send_item(wgm_pkg::OP_TEXT, 8'h00);
		send_end();
		// Literal, any-byte and a zero byte as ordinary pattern bytes.
		glob_pat.delete();
		send_item(wgm_pkg::OP_CLEAR, 8'hFF);
		send_append(8'h61);
		send_append(wgm_pkg::ANY_BYTE);
		send_append(8'h00);
		send_item(wgm_pkg::OP_TEXT, 8'h61);
		send_item(wgm_pkg::OP_TEXT, 8'h5A);
		send_item(wgm_pkg::OP_TEXT, 8'h00);
		send_end();
		// Grow the pattern in the middle of a text.
		send_clear();
		send_append(8'h78);
		send_item(wgm_pkg::OP_TEXT, 8'h78);
		send_append(8'h79);
		send_item(wgm_pkg::OP_TEXT, 8'h79);
		send_end();

		// Random: mostly well-formed pattern-then-texts runs, some noise and
		// some broken sequences.
		while (items_sent < ITEM_GOAL) begin
			calm = ($urandom_range(0, 3) == 0);
			if (!pressed && items_sent >= ITEM_GOAL / 3) begin
				// Stall the output for a long time while short texts keep
				// coming back to back, so the block has to stall its input.
				pressed = 1'b1;
				calm = 1'b1;
				hold_results = 1'b1;
				repeat (8) send_text(1'($urandom_range(0, 1)), 1'b0);
				continue;
			end
			if (!paused && items_sent >= 2 * ITEM_GOAL / 3) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				wait_drained();
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				load_pattern();
				repeat ($urandom_range(1, 4))
					send_text($urandom_range(0, 2) != 0, $urandom_range(0, 9) == 0);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 6))
					send_item(wgm_pkg::op_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
			end else if (r < 93) begin
				// Keep the old pattern and stream a text without a fresh clear.
				send_text(1'($urandom_range(0, 1)), 1'b0);
			end else begin
				// Clear halfway through a text; the tail meets an empty pattern.
				repeat ($urandom_range(1, 4)) send_item(wgm_pkg::OP_TEXT, pick_byte());
				send_clear();
				if ($urandom_range(0, 1))
					send_item(wgm_pkg::OP_TEXT, pick_byte());
				send_end();
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (!verdicts.drained()) begin
			$error("%0d expected results never arrived", verdicts.awaited.size());
			verdicts.failures++;
		end
		if (verdicts.failures == 0)
			$display("PASS wildcard_glob_matcher");
		else
			$display("FAIL wildcard_glob_matcher");
		$finish;
	end

endmodule
